// ===== hw/rtl/lsc_pkg.sv =====
// Shared types and constants for the 3D line segment clipper.
// Used by lsc_div_cell, lsc_clip_stage and line_segment_clip_3d.
package lsc_pkg;

    localparam int unsigned CW        = 32;   // coordinate width, signed 16.16
    localparam int unsigned NCOORD    = 3;    // x, y, depth
    localparam int unsigned QBITS     = 32;   // quotient bits, one per divider cell
    localparam logic [CW-1:0] DEPTH_NEAR = 32'sd0;
    localparam logic [CW-1:0] DEPTH_FAR  = 32'sd65536;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_TOP    = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    // Segment in flight; element 0 is x, 1 is y, 2 is depth.
    typedef struct packed {
        logic                           vis;
        logic [NCOORD-1:0][CW-1:0]      p;
        logic [NCOORD-1:0][CW-1:0]      q;
    } t_seg;

    // Per-stage move control carried beside the segment.
    typedef struct packed {
        logic           mv_p;
        logic           mv_q;
        logic [1:0]     neg;   // sign of inside-minus-outside, x and y lanes
        logic [CW-1:0]  den;
    } t_ctl;

    // One divider lane: partial remainder and dividend/quotient shift word.
    typedef struct packed {
        logic [CW-1:0]  rem;
        logic [CW-1:0]  lq;
    } t_lane;

endpackage

// ===== hw/rtl/lsc_div_cell.sv =====
// One restoring-division cell: retires one quotient bit on two lanes.
// Depends on lsc_pkg; chained by lsc_clip_stage.
module lsc_div_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  lsc_pkg::t_seg          i_seg,
    input  lsc_pkg::t_ctl          i_ctl,
    input  lsc_pkg::t_lane [1:0]   i_lane,
    output logic                   o_valid,
    output lsc_pkg::t_seg          o_seg,
    output lsc_pkg::t_ctl          o_ctl,
    output lsc_pkg::t_lane [1:0]   o_lane
);

    logic                   r_valid;
    lsc_pkg::t_seg          r_seg;
    lsc_pkg::t_ctl          r_ctl;
    lsc_pkg::t_lane [1:0]   r_lane;
    lsc_pkg::t_lane [1:0]   n_lane;

    always_comb begin
        logic [lsc_pkg::CW:0] t;
        logic [lsc_pkg::CW:0] d;
        logic                 ge;
        for (int l = 0; l < 2; l++) begin
            t  = {i_lane[l].rem, i_lane[l].lq[lsc_pkg::CW-1]};
            d  = t - {1'b0, i_ctl.den};
            ge = (t >= {1'b0, i_ctl.den});
            n_lane[l].rem = ge ? d[lsc_pkg::CW-1:0] : t[lsc_pkg::CW-1:0];
            n_lane[l].lq  = {i_lane[l].lq[lsc_pkg::CW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_seg  <= i_seg;
            r_ctl  <= i_ctl;
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_seg   = r_seg;
    assign o_ctl   = r_ctl;
    assign o_lane  = r_lane;

endmodule

// ===== hw/rtl/lsc_clip_stage.sv =====
// One clip plane: classify, multiply, divide over a chain of cells, move endpoint.
// Depends on lsc_pkg and lsc_div_cell.
module lsc_clip_stage #(
    parameter int unsigned AXIS  = 0,
    parameter bit          ABOVE = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [lsc_pkg::CW-1:0]  i_plane,
    input  logic                    i_valid,
    input  lsc_pkg::t_seg           i_seg,
    output logic                    o_valid,
    output lsc_pkg::t_seg           o_seg
);

    localparam int unsigned CW = lsc_pkg::CW;
    localparam int unsigned NC = lsc_pkg::QBITS;

    // classify and take magnitudes
    logic                   r0_valid;
    lsc_pkg::t_seg          r0_seg,  n0_seg;
    lsc_pkg::t_ctl          r0_ctl,  n0_ctl;
    logic [1:0][CW-1:0]     r0_mag,  n0_mag;
    logic [CW-1:0]          r0_num,  n0_num;

    always_comb begin
        logic                      po, qo;
        logic [lsc_pkg::NCOORD-1:0][CW-1:0] o, ii;
        logic [CW:0]               d;
        po = ABOVE ? ($signed(i_seg.p[AXIS]) > $signed(i_plane))
                   : ($signed(i_seg.p[AXIS]) < $signed(i_plane));
        qo = ABOVE ? ($signed(i_seg.q[AXIS]) > $signed(i_plane))
                   : ($signed(i_seg.q[AXIS]) < $signed(i_plane));
        n0_seg      = i_seg;
        n0_seg.vis  = i_seg.vis & ~(po & qo);
        n0_ctl.mv_p = i_seg.vis & po & ~qo;
        n0_ctl.mv_q = i_seg.vis & qo & ~po;
        o  = n0_ctl.mv_p ? i_seg.p : i_seg.q;
        ii = n0_ctl.mv_p ? i_seg.q : i_seg.p;
        d = {ii[AXIS][CW-1], ii[AXIS]} - {o[AXIS][CW-1], o[AXIS]};
        n0_ctl.den = d[CW] ? CW'(-d) : d[CW-1:0];
        d = {i_plane[CW-1], i_plane} - {o[AXIS][CW-1], o[AXIS]};
        n0_num = d[CW] ? CW'(-d) : d[CW-1:0];
        for (int c = 0; c < 2; c++) begin
            d = {ii[c][CW-1], ii[c]} - {o[c][CW-1], o[c]};
            n0_ctl.neg[c] = d[CW];
            n0_mag[c]     = d[CW] ? CW'(-d) : d[CW-1:0];
        end
    end

    // multiply
    logic                   r1_valid;
    lsc_pkg::t_seg          r1_seg;
    lsc_pkg::t_ctl          r1_ctl;
    logic [1:0][2*CW-1:0]   r1_prod;

    // add rounding half and load the divider
    logic                   r2_valid;
    lsc_pkg::t_seg          r2_seg;
    lsc_pkg::t_ctl          r2_ctl;
    lsc_pkg::t_lane [1:0]   r2_lane, n2_lane;

    always_comb begin
        logic [2*CW-1:0] s;
        for (int c = 0; c < 2; c++) begin
            s = r1_prod[c] + {{(CW+1){1'b0}}, r1_ctl.den[CW-1:1]};
            n2_lane[c].rem = s[2*CW-1:CW];
            n2_lane[c].lq  = s[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r0_seg  <= n0_seg;
            r0_ctl  <= n0_ctl;
            r0_mag  <= n0_mag;
            r0_num  <= n0_num;
            r1_seg  <= r0_seg;
            r1_ctl  <= r0_ctl;
            for (int c = 0; c < 2; c++) begin
                r1_prod[c] <= r0_mag[c] * r0_num;
            end
            r2_seg  <= r1_seg;
            r2_ctl  <= r1_ctl;
            r2_lane <= n2_lane;
        end
    end

    // divider chain, one quotient bit per cell
    logic                   c_valid [NC+1];
    lsc_pkg::t_seg          c_seg   [NC+1];
    lsc_pkg::t_ctl          c_ctl   [NC+1];
    lsc_pkg::t_lane [1:0]   c_lane  [NC+1];

    assign c_valid[0] = r2_valid;
    assign c_seg[0]   = r2_seg;
    assign c_ctl[0]   = r2_ctl;
    assign c_lane[0]  = r2_lane;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        lsc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_valid[g]),
            .i_seg   (c_seg[g]),
            .i_ctl   (c_ctl[g]),
            .i_lane  (c_lane[g]),
            .o_valid (c_valid[g+1]),
            .o_seg   (c_seg[g+1]),
            .o_ctl   (c_ctl[g+1]),
            .o_lane  (c_lane[g+1])
        );
    end

    // move the outside endpoint onto the plane
    logic                   r3_valid;
    lsc_pkg::t_seg          r3_seg, n3_seg;

    always_comb begin
        lsc_pkg::t_seg s;
        lsc_pkg::t_ctl k;
        s = c_seg[NC];
        k = c_ctl[NC];
        n3_seg = s;
        for (int c = 0; c < 2; c++) begin
            if (c != AXIS) begin
                if (k.mv_p) begin
                    n3_seg.p[c] = k.neg[c] ? s.p[c] - c_lane[NC][c].lq
                                           : s.p[c] + c_lane[NC][c].lq;
                end
                if (k.mv_q) begin
                    n3_seg.q[c] = k.neg[c] ? s.q[c] - c_lane[NC][c].lq
                                           : s.q[c] + c_lane[NC][c].lq;
                end
            end
        end
        if (k.mv_p) begin
            n3_seg.p[AXIS] = i_plane;
        end
        if (k.mv_q) begin
            n3_seg.q[AXIS] = i_plane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= c_valid[NC];
        end
        if (i_en) begin
            r3_seg <= n3_seg;
        end
    end

    assign o_valid = r3_valid;
    assign o_seg   = r3_seg;

endmodule

// ===== hw/rtl/line_segment_clip_3d.sv =====
// Top level of the 3D line segment clipper; holds the window bound registers.
// Depends on lsc_pkg and lsc_clip_stage (which uses lsc_div_cell).
//
// Clips one window-space segment per beat against left, right, top, bottom,
// near (depth 0) and far (depth 1.0) in that order, all in signed 16.16.
// A new segment is taken every clock unless the output stalls. There are six
// clip stages of 36 registers each (classify, 32x32 multiply, rounding add,
// a chain of 32 restoring-division cells that retire one quotient bit
// per cycle, endpoint move). The whole pipeline holds while the output beat
// waits. Rejected segments come out with visible low and all endpoints zero.
// Write the bound registers only while no segment is in flight.
module line_segment_clip_3d (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // bound register write port: 0 left, 1 right, 2 top, 3 bottom
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_wr_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // first_x, first_y, first_depth, second_x, second_y, second_depth
    input  logic [191:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // out_first_x/_y/_depth, out_second_x/_y/_depth
    output logic [191:0]  m_axis_tdata,
    // visible
    output logic          m_axis_tuser
);

    localparam int unsigned CW     = lsc_pkg::CW;
    localparam int unsigned NSTAGE = 6;

    logic [CW-1:0] r_left, r_right, r_top, r_bottom;

    // hold the bounds; reset to 20.0 and 500.0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= 32'sd1310720;
            r_right  <= 32'sd32768000;
            r_top    <= 32'sd1310720;
            r_bottom <= 32'sd32768000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                lsc_pkg::REG_LEFT:   r_left   <= i_cfg_wr_data;
                lsc_pkg::REG_RIGHT:  r_right  <= i_cfg_wr_data;
                lsc_pkg::REG_TOP:    r_top    <= i_cfg_wr_data;
                lsc_pkg::REG_BOTTOM: r_bottom <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // advance everything when the output register is free or being drained
    logic en;
    assign en            = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = en;

    logic          st_valid [NSTAGE+1];
    lsc_pkg::t_seg st_seg   [NSTAGE+1];
    logic [CW-1:0] st_plane [NSTAGE];

    assign st_plane[0] = r_left;
    assign st_plane[1] = r_right;
    assign st_plane[2] = r_top;
    assign st_plane[3] = r_bottom;
    assign st_plane[4] = lsc_pkg::DEPTH_NEAR;
    assign st_plane[5] = lsc_pkg::DEPTH_FAR;

    always_comb begin
        st_valid[0]   = s_axis_tvalid;
        st_seg[0].vis = 1'b1;
        for (int c = 0; c < 3; c++) begin
            st_seg[0].p[c] = s_axis_tdata[c*CW +: CW];
            st_seg[0].q[c] = s_axis_tdata[(c+3)*CW +: CW];
        end
    end

    for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
        lsc_clip_stage #(
            .AXIS  (k / 2),
            .ABOVE (1'(k % 2))
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_plane (st_plane[k]),
            .i_valid (st_valid[k]),
            .i_seg   (st_seg[k]),
            .o_valid (st_valid[k+1]),
            .o_seg   (st_seg[k+1])
        );
    end

    // last stage register is the output beat; zero the endpoints on reject
    assign m_axis_tvalid = st_valid[NSTAGE];
    assign m_axis_tuser  = st_seg[NSTAGE].vis;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            m_axis_tdata[c*CW +: CW]     = st_seg[NSTAGE].vis ? st_seg[NSTAGE].p[c] : '0;
            m_axis_tdata[(c+3)*CW +: CW] = st_seg[NSTAGE].vis ? st_seg[NSTAGE].q[c] : '0;
        end
    end

endmodule

// ===== dv/line_segment_clip_3d_tb.sv =====
// Self-checking testbench for the 3D line segment clipper (line_segment_clip_3d).
// Depends on lsc_pkg for the bound register indexes; drives both stream ports
// and predicts each clipped segment in plain 64-bit integer arithmetic.
module line_segment_clip_3d_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 260;
    localparam int LONG_HOLD       = 1500;
    localparam longint ONE         = 65536;

    // One point as x, y, depth in wide signed integers.
    typedef struct {
        longint c[3];
    } t_point;

    typedef struct {
        bit           vis;
        logic [191:0] pts;
    } t_clip_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [1:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_wr_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // first_x, first_y, first_depth, second_x, second_y, second_depth
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // out_first_x/_y/_depth, out_second_x/_y/_depth
    logic [191:0] m_axis_tdata;
    // visible
    logic         m_axis_tuser;

    line_segment_clip_3d u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Local copy of the four window bounds.
    longint bound_left, bound_right, bound_top, bound_bottom;

    t_clip_result clipped_q[$];
    int  mismatches = 0;
    bit  allow_idle = 1'b1;
    bit  hold_request = 1'b0;

    // ------------------------------------------------------------------
    // Clip predictor
    // ------------------------------------------------------------------
    function automatic bit [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Move outside point o onto the plane along axis ax, toward inside point b.
    // x and y stages leave depth alone; depth stages move both x and y.
    function automatic t_point move_onto(t_point o, t_point b, int ax, longint plane);
        bit [63:0] den, num, step;
        longint    diff;
        den = magnitude(b.c[ax] - o.c[ax]);
        num = magnitude(plane - o.c[ax]);
        if (den != 0) begin
            for (int c = 0; c < 3; c++) begin
                if (c == ax || (ax < 2 && c == 2)) continue;
                diff = b.c[c] - o.c[c];
                // halves round away from the outside point
                step = (magnitude(diff) * num + den / 2) / den;
                o.c[c] = (diff < 0) ? o.c[c] - longint'(step) : o.c[c] + longint'(step);
            end
        end
        o.c[ax] = plane;
        return o;
    endfunction

    // One plane; returns 0 when both ends are outside (on the plane is inside).
    function automatic bit clip_plane(inout t_point a, inout t_point b, input int ax,
                                      input longint plane, input bit above);
        bit a_out, b_out;
        a_out = above ? (a.c[ax] > plane) : (a.c[ax] < plane);
        b_out = above ? (b.c[ax] > plane) : (b.c[ax] < plane);
        if (a_out && b_out) return 1'b0;
        if (a_out) a = move_onto(a, b, ax, plane);
        else if (b_out) b = move_onto(b, a, ax, plane);
        return 1'b1;
    endfunction

    function automatic t_clip_result clip_segment(logic [191:0] seg);
        t_point a, b;
        t_clip_result r;
        for (int k = 0; k < 3; k++) begin
            a.c[k] = longint'($signed(seg[32*k +: 32]));
            b.c[k] = longint'($signed(seg[32*(k+3) +: 32]));
        end
        r.vis = clip_plane(a, b, 0, bound_left, 1'b0)
             && clip_plane(a, b, 0, bound_right, 1'b1)
             && clip_plane(a, b, 1, bound_top, 1'b0)
             && clip_plane(a, b, 1, bound_bottom, 1'b1)
             && clip_plane(a, b, 2, 0, 1'b0)
             && clip_plane(a, b, 2, ONE, 1'b1);
        r.pts = '0;
        if (r.vis) begin
            for (int k = 0; k < 3; k++) begin
                r.pts[32*k +: 32]     = a.c[k][31:0];
                r.pts[32*(k+3) +: 32] = b.c[k][31:0];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one segment; record its expected result on the accepting edge.
    task automatic send_segment(logic [191:0] seg);
        bit go;
        if (allow_idle && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= seg;
        forever begin
            // all inputs change only at rising edges, so the falling edge
            // shows what the next rising edge will see
            @(negedge i_clk);
            go = s_axis_tready;
            @(posedge i_clk);
            if (go) break;
        end
        clipped_q.push_back(clip_segment(seg));
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for the pipe to empty; every segment gives a result, so an empty
    // queue means nothing is in flight.
    task automatic wait_drained();
        while (clipped_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_bound(logic [1:0] idx, logic [31:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        case (idx)
            lsc_pkg::REG_LEFT:   bound_left   = longint'($signed(value));
            lsc_pkg::REG_RIGHT:  bound_right  = longint'($signed(value));
            lsc_pkg::REG_TOP:    bound_top    = longint'($signed(value));
            lsc_pkg::REG_BOTTOM: bound_bottom = longint'($signed(value));
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_window(logic [31:0] l, logic [31:0] r, logic [31:0] t, logic [31:0] b);
        write_bound(lsc_pkg::REG_LEFT, l);
        write_bound(lsc_pkg::REG_RIGHT, r);
        write_bound(lsc_pkg::REG_TOP, t);
        write_bound(lsc_pkg::REG_BOTTOM, b);
    endtask

    function automatic logic [191:0] pack_seg(longint fx, longint fy, longint fd,
                                              longint sx, longint sy, longint sd);
        return {sd[31:0], sy[31:0], sx[31:0], fd[31:0], fy[31:0], fx[31:0]};
    endfunction

    // Coordinate biased toward the bounds lo..hi: near an edge, inside,
    // around them, or anywhere in the 32-bit range.
    function automatic longint pick_coord(longint lo, longint hi);
        longint v;
        case ($urandom_range(0, 5))
            0: v = longint'($signed($urandom()));
            1: v = lo + longint'($urandom_range(0, 4000)) - 2000;
            2: v = hi + longint'($urandom_range(0, 4000)) - 2000;
            3: v = lo + longint'($urandom_range(0, 4)) - 2;
            default: v = lo + (longint'($urandom()) % (hi - lo + 3 * ONE + 1)) - ONE;
        endcase
        return longint'($signed(v[31:0]));
    endfunction

    function automatic logic [191:0] random_seg();
        longint fx, fy, fd, sx, sy, sd;
        fx = pick_coord(bound_left, bound_right);
        fy = pick_coord(bound_top, bound_bottom);
        fd = pick_coord(0, ONE);
        sx = pick_coord(bound_left, bound_right);
        sy = pick_coord(bound_top, bound_bottom);
        sd = pick_coord(0, ONE);
        // axis-parallel and degenerate segments
        case ($urandom_range(0, 9))
            0: sx = fx;
            1: sy = fy;
            2: sd = fd;
            3: begin sx = fx; sy = fy; sd = fd; end
            default: ;
        endcase
        return pack_seg(fx, fy, fd, sx, sy, sd);
    endfunction

    // ------------------------------------------------------------------
    // Result sink: random stalls plus the long hold asked for by the
    // pressure test.
    // ------------------------------------------------------------------
    initial begin
        int  stall_left;
        bit  ready_next;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
                ready_next = 1'b0;
            end else if (allow_idle && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 17);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_axis_tready <= ready_next;
        end
    end

    // Result checker: compare each accepted beat with the oldest expectation.
    initial begin
        string        names[6] = '{"first_x", "first_y", "first_depth",
                                   "second_x", "second_y", "second_depth"};
        bit           take;
        logic [191:0] got_pts;
        logic         got_vis;
        t_clip_result want;
        forever begin
            @(negedge i_clk);
            take    = m_axis_tvalid && m_axis_tready && i_rst_n;
            got_pts = m_axis_tdata;
            got_vis = m_axis_tuser;
            @(posedge i_clk);
            if (take) begin
                if (clipped_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: visible=%0b data=%h", got_vis, got_pts);
                end else begin
                    want = clipped_q.pop_front();
                    if (got_vis !== want.vis) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("visible: expected %0b, got %0b", want.vis, got_vis);
                    end
                    for (int k = 0; k < 6; k++) begin
                        if (got_pts[32*k +: 32] !== want.pts[32*k +: 32]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("%s: expected %h, got %h", names[k],
                                         want.pts[32*k +: 32], got_pts[32*k +: 32]);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either side.
    initial begin
        int quiet_cycles;
        bit moved;
        quiet_cycles = 0;
        forever begin
            @(negedge i_clk);
            moved = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready);
            @(posedge i_clk);
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("line_segment_clip_3d_tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Hand-picked segments under the reset window (20..500 on x and y).
    task automatic test_directed();
        longint l, r, t, b;
        l = bound_left; r = bound_right; t = bound_top; b = bound_bottom;
        send_segment(pack_seg(100 * ONE, 100 * ONE, ONE / 2, 200 * ONE, 300 * ONE, ONE / 4));
        send_segment(pack_seg(5 * ONE, 100 * ONE, 0, 10 * ONE, 200 * ONE, ONE));     // both left
        send_segment(pack_seg(5 * ONE, 100 * ONE, 0, 300 * ONE, 200 * ONE, ONE));   // crosses left
        send_segment(pack_seg(100 * ONE, 100 * ONE, 0, 600 * ONE, 300 * ONE, ONE));  // crosses right
        send_segment(pack_seg(100 * ONE, 5 * ONE, 0, 300 * ONE, 200 * ONE, ONE));   // crosses top
        send_segment(pack_seg(100 * ONE, 100 * ONE, 0, 300 * ONE, 900 * ONE, ONE)); // crosses bottom
        send_segment(pack_seg(100 * ONE, 100 * ONE, -ONE, 300 * ONE, 200 * ONE, ONE)); // near
        send_segment(pack_seg(100 * ONE, 100 * ONE, 0, 300 * ONE, 200 * ONE, 3 * ONE)); // far
        send_segment(pack_seg(100 * ONE, 100 * ONE, -5, 300 * ONE, 200 * ONE, -1));  // both near
        send_segment(pack_seg(100 * ONE, 100 * ONE, ONE + 1, 300 * ONE, 200 * ONE, 2 * ONE));
        // axis-parallel lines crossing a plane
        send_segment(pack_seg(150 * ONE, 5 * ONE, ONE / 2, 150 * ONE, 700 * ONE, ONE / 2));
        send_segment(pack_seg(2 * ONE, 150 * ONE, ONE / 2, 900 * ONE, 150 * ONE, ONE / 2));
        // endpoints exactly on the planes and just outside them
        send_segment(pack_seg(l, t, 0, r, b, ONE));
        send_segment(pack_seg(l - 1, t, 0, r + 1, b, ONE));
        // single point
        send_segment(pack_seg(200 * ONE, 200 * ONE, 7, 200 * ONE, 200 * ONE, 7));
        // field extremes, then a tiny segment at the origin
        send_segment(pack_seg(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                              64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF));
        send_segment(pack_seg(64'sh7FFF_FFFF, -64'sh8000_0000, 64'sh7FFF_FFFF,
                              -64'sh8000_0000, 64'sh7FFF_FFFF, -64'sh8000_0000));
        send_segment(pack_seg(-1, -1, -1, 0, 0, 0));
        // clipped on every plane
        send_segment(pack_seg(-100 * ONE, -50 * ONE, -2 * ONE, 900 * ONE, 800 * ONE, 4 * ONE));
        send_segment(pack_seg(900 * ONE, -50 * ONE, 4 * ONE, -100 * ONE, 800 * ONE, -2 * ONE));
        stop_sending();
    endtask

    task automatic test_random_mix(int count);
        for (int n = 0; n < count; n++) send_segment(random_seg());
        stop_sending();
    endtask

    // Several windows including the full range, crossed bounds and a zero-width one.
    task automatic test_windows();
        set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        test_random_mix(150);
        set_window(32'hFFF0_0000, 32'h0010_0000, 32'hFFFF_0000, 32'h0001_0000);
        test_random_mix(200);
        set_window(32'h0050_0000, 32'h0010_0000, 32'h0001_0000, 32'h0020_0000);   // crossed x
        test_random_mix(60);
        set_window(32'h0001_0000, 32'h0020_0000, 32'h0050_0000, 32'h0010_0000);   // crossed y
        test_random_mix(60);
        set_window(32'h0003_0000, 32'h0003_0000, 32'h0000_0000, 32'h7FFF_FFFF);   // zero width
        test_random_mix(80);
        set_window($urandom(), $urandom(), $urandom(), $urandom());
        test_random_mix(50);
        set_window(32'h0014_0000, 32'h01F4_0000, 32'h0014_0000, 32'h01F4_0000);
    endtask

    // Hold the result side off long enough to fill the pipe and stall input.
    task automatic test_backpressure();
        hold_request = 1'b1;
        test_random_mix(400);
    endtask

    initial begin
        bound_left   = 1310720;
        bound_right  = 32768000;
        bound_top    = 1310720;
        bound_bottom = 32768000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(130);
        test_windows();
        test_backpressure();
        allow_idle = 1'b0;
        test_random_mix(100);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && clipped_q.size() == 0) begin
            $display("line_segment_clip_3d_tb passed");
        end else begin
            $display("line_segment_clip_3d_tb failed");
        end
        $finish;
    end

endmodule
